// ----- hdl/ipv4dq_pkg.sv -----
package ipv4dq_pkg;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [8:0] OCTET_MAX  = 9'd255;
    localparam logic [8:0] OCTET_SAT  = 9'd256;
    localparam logic [2:0] DOTS_NEEDED = 3'd3;
    localparam logic [2:0] DOTS_SAT   = 3'd7;
    localparam logic [1:0] DIGITS_SAT = 2'd3;

    localparam int CHAR_W = 8;
    localparam int ADDR_W = 32;

    typedef struct packed {
        logic [8:0]  octet_value;
        logic [2:0]  dot_count;
        logic [1:0]  octet_digits;
        logic        leading_zero;
        logic        error_seen;
        logic [23:0] address_so_far;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '0;

endpackage

// ----- hdl/ipv4_dotted_quad_parser_top.sv -----
// dotted-decimal ipv4 address parser
//
// input channel s_*: one ascii character per beat in s_tdata[7:0], s_tlast
// marks the final character of the address string. output channel m_*: one
// beat per string, sent after the final character, with the 32-bit address
// in m_tdata (first octet in bits 31..24) and the valid flag in m_tuser[0].
// an invalid string gives valid 0 and address 0.
//
// the result is registered: it appears on m_* in the cycle after the final
// character is taken. throughput: one character per cycle while s_tready is
// high; the per-character update, a small multiply-by-ten and compare on the
// octet register, is combinational between parser state and result registers.
//
// reset clears the parser state and the output valid flag; the parser state is
// also cleared after every final character, so strings may follow back to
// back. while the receiver stalls with a result pending, s_tready stays high
// unless another final character would have to overwrite that result.
module ipv4_dotted_quad_parser_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ipv4dq_pkg::CHAR_W-1:0]  s_tdata,   // character
    input  logic                           s_tlast,   // end_of_string
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ipv4dq_pkg::ADDR_W-1:0]  m_tdata,   // address
    output logic [0:0]                     m_tuser    // valid_res
);
    import ipv4dq_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t upd;

    logic                  m_tvalid_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  ok_reg;

    logic                  s_accept;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [12:0]           acc;
    logic                  ok;
    logic [ADDR_W-1:0]     addr_out;

    assign s_tready = !m_tvalid_reg || m_tready || !s_tlast;
    assign s_accept = s_tvalid && s_tready;

    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit    = 4'(s_tdata - CHAR_ZERO);
    assign acc      = 13'({state_reg.octet_value, 3'b000}) + 13'({state_reg.octet_value, 1'b0})
                    + 13'(digit);

    always_comb
    begin
        upd = state_reg;
        if (s_tdata == CHAR_DOT)
        begin
            if (state_reg.octet_digits == 2'd0 || state_reg.octet_value > OCTET_MAX)
            begin
                upd.error_seen = 1'b1;
            end
            if (state_reg.dot_count < DOTS_SAT)
            begin
                upd.dot_count = state_reg.dot_count + 3'd1;
            end
            if (upd.dot_count > DOTS_NEEDED)
            begin
                upd.error_seen = 1'b1;
            end
            upd.address_so_far = {state_reg.address_so_far[15:0], state_reg.octet_value[7:0]};
            upd.octet_value    = '0;
            upd.octet_digits   = '0;
            upd.leading_zero   = 1'b0;
        end
        else if (is_digit)
        begin
            if (state_reg.leading_zero)
            begin
                upd.error_seen = 1'b1;
            end
            if (state_reg.octet_digits == 2'd0 && digit == 4'd0)
            begin
                upd.leading_zero = 1'b1;
            end
            if (acc >= 13'(OCTET_SAT))
            begin
                upd.octet_value = OCTET_SAT;
                upd.error_seen  = 1'b1;
            end
            else
            begin
                upd.octet_value = acc[8:0];
            end
            if (state_reg.octet_digits < DIGITS_SAT)
            begin
                upd.octet_digits = state_reg.octet_digits + 2'd1;
            end
        end
        else
        begin
            upd.error_seen = 1'b1;
        end
    end

    assign ok = !upd.error_seen && (upd.dot_count == DOTS_NEEDED)
             && (upd.octet_digits != 2'd0) && (upd.octet_value <= OCTET_MAX);
    assign addr_out = ok ? {upd.address_so_far, upd.octet_value[7:0]} : '0;

    always_comb
    begin
        state_next = state_reg;
        if (s_accept)
        begin
            state_next = s_tlast ? PARSE_CLEAR : upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PARSE_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_accept && s_tlast)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && s_tlast)
        begin
            addr_reg <= addr_out;
            ok_reg   <= ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = addr_reg;
    assign m_tuser  = ok_reg;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid result with nonzero address");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (state_reg == PARSE_CLEAR))
        else $error("parser state not cleared after final character");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result appeared without a final character");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !(s_tvalid && s_tready && s_tlast))
        else $error("pending result overwritten");
`endif

endmodule

// ----- sim/ipv4_dotted_quad_parser_top_tb.sv -----
module ipv4_dotted_quad_parser_top_tb;

    import ipv4dq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_CHARS = 1600;

    typedef struct {
        logic [7:0]  ch;
        logic        last;
        int unsigned gap;
        bit          drain;
    } char_beat_t;

    typedef struct {
        logic        valid_res;
        logic [31:0] address;
    } parse_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ADDR_W-1:0] m_tdata;
    logic [0:0]        m_tuser;

    char_beat_t    char_feed[$];
    parse_result_t pending_results[$];
    logic [7:0]    text[$];

    // predicted parser state
    logic [8:0]  octet_acc = '0;
    logic [2:0]  dots_seen = '0;
    logic [1:0]  digit_cnt = '0;
    logic        zero_lead = 1'b0;
    logic        syntax_err = 1'b0;
    logic [23:0] addr_acc = '0;

    int unsigned gap_count = 0;
    int unsigned ready_wait = 0;
    int unsigned chars_sent = 0;
    int unsigned strings_made = 0;
    int unsigned results_seen = 0;
    int unsigned valid_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    ipv4_dotted_quad_parser_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic bit parse_char(input logic [7:0] ch, input logic last,
                                      output parse_result_t res);
        int unsigned v;
        res = '{1'b0, 32'd0};
        if (ch == CHAR_DOT)
        begin
            if (digit_cnt == 0 || octet_acc > OCTET_MAX)
                syntax_err = 1'b1;
            if (dots_seen < DOTS_SAT)
                dots_seen++;
            if (dots_seen > DOTS_NEEDED)
                syntax_err = 1'b1;
            addr_acc = {addr_acc[15:0], octet_acc[7:0]};
            octet_acc = '0;
            digit_cnt = '0;
            zero_lead = 1'b0;
        end
        else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            if (zero_lead)
                syntax_err = 1'b1;
            if (digit_cnt == 0 && ch == CHAR_ZERO)
                zero_lead = 1'b1;
            v = int'(octet_acc) * 10 + int'(ch - CHAR_ZERO);
            if (v >= OCTET_SAT)
            begin
                v = OCTET_SAT;
                syntax_err = 1'b1;
            end
            octet_acc = v[8:0];
            if (digit_cnt < DIGITS_SAT)
                digit_cnt++;
        end
        else
            syntax_err = 1'b1;
        if (!last)
            return 1'b0;
        res.valid_res = !syntax_err && dots_seen == DOTS_NEEDED && digit_cnt != 0 &&
                        octet_acc <= OCTET_MAX;
        if (res.valid_res)
            res.address = {addr_acc, octet_acc[7:0]};
        octet_acc = '0;
        dots_seen = '0;
        digit_cnt = '0;
        zero_lead = 1'b0;
        syntax_err = 1'b0;
        addr_acc = '0;
        return 1'b1;
    endfunction

    task automatic append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    // move the working string into the feed, end mark on its final character
    task automatic queue_text();
        char_beat_t beat;
        bit calm;
        calm = (strings_made / 20) % 4 == 1;
        for (int i = 0; i < text.size(); i++)
        begin
            beat.ch = text[i];
            beat.last = (i == text.size() - 1);
            beat.gap = calm ? 0 : $urandom_range(0, 11);
            beat.drain = (i == 0) && (strings_made % 25 == 24);
            char_feed.push_back(beat);
        end
        text.delete();
        strings_made++;
    endtask

    task automatic make_address_text();
        int unsigned kind;
        int unsigned n_oct;
        int unsigned bad;
        int unsigned pick;
        int unsigned pos;
        kind = $urandom_range(0, 9);
        n_oct = 4;
        if (kind == 8)
            n_oct = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(5, 6);
        bad = $urandom_range(0, n_oct - 1);
        for (int k = 0; k < n_oct; k++)
        begin
            if (k != 0)
                text.push_back(CHAR_DOT);
            if (k == bad && kind == 5)
                append_text($sformatf("%0d", $urandom_range(256, 99999)));
            else if (k == bad && kind == 6)
                append_text($sformatf("0%0d", $urandom_range(0, 255)));
            else if (!(k == bad && kind == 7))
            begin
                pick = $urandom_range(0, 5);
                case (pick)
                    0: append_text("0");
                    1: append_text("255");
                    2: append_text($sformatf("%0d", $urandom_range(0, 9)));
                    default: append_text($sformatf("%0d", $urandom_range(0, 255)));
                endcase
            end
        end
        if (kind == 9)
        begin
            pick = $urandom_range(0, 2);
            pos = $urandom_range(0, text.size() - 1);
            if (pick == 0)
                text[pos] = 8'($urandom_range(0, 255));
            else if (pick == 1)
                text.insert(pos, 8'($urandom_range(0, 255)));
            else
            begin
                text.delete();
                repeat ($urandom_range(1, 6))
                    text.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_chars
        parse_result_t res;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            gap_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (parse_char(s_tdata, s_tlast, res))
                    pending_results.push_back(res);
                chars_sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (char_feed.size() != 0 && gap_count >= char_feed[0].gap &&
                    !(char_feed[0].drain && (m_tvalid || pending_results.size() != 0)))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= char_feed[0].ch;
                    s_tlast <= char_feed[0].last;
                    void'(char_feed.pop_front());
                    gap_count <= 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    if (char_feed.size() != 0 && gap_count < char_feed[0].gap)
                        gap_count <= gap_count + 1;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : check_results
        parse_result_t want;
        int unsigned stall;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            ready_wait <= 0;
        end
        else
        begin
            stall = ready_wait;
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected beat: valid_res %0b address %h", m_tuser[0], m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser[0] !== want.valid_res)
                    begin
                        $error("valid_res: expected %0b, got %0b", want.valid_res, m_tuser[0]);
                        mismatches++;
                    end
                    if (m_tdata !== want.address)
                    begin
                        $error("address: expected %h, got %h", want.address, m_tdata);
                        mismatches++;
                    end
                    if (want.valid_res)
                        valid_seen++;
                end
                results_seen++;
                stall = ((results_seen / 8) % 4 == 1) ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                ready_wait <= stall - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                ready_wait <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        // directed strings
        append_text("1.0.255.9");
        queue_text();
        append_text("256");
        queue_text();
        append_text("01");
        queue_text();
        append_text("..");
        queue_text();
        text.push_back(8'h00);
        queue_text();
        text.push_back(8'hFF);
        queue_text();
        append_text("....");
        queue_text();
        while (char_feed.size() < RANDOM_CHARS)
        begin
            make_address_text();
            queue_text();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (char_feed.size() != 0 || s_tvalid)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("%0d characters in %0d strings sent, %0d results checked (%0d valid)",
                 chars_sent, strings_made, results_seen, valid_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
